/* design/sobel_et_pkg.sv */
// shared types and constants of the sobel edge threshold stream unit
// no dependencies; imported by the top level
`default_nettype none

package sobel_et_pkg;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        last_in_step;
    } result_t;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd768;

    // squared gradient magnitude and its threshold (50 * 4, squared)
    localparam int          MAG_W      = 21;
    localparam logic [20:0] EDGE_LIMIT = 21'd40000;

    localparam logic [7:0] PIX_WHITE = 8'd255;
    localparam logic [7:0] PIX_BLACK = 8'd0;

endpackage

`default_nettype wire

/* design/sobel_edge_threshold_stream_unit.sv */
// top level of the sobel edge threshold stream unit
// depends on sobel_et_pkg and sobel_et_ram
//
// usage:
//   pix channel (pix_valid / pix_stall / pix_data) takes one rgb pixel per word
//   in raster order; the unit counts row and column itself and wraps to row 0,
//   column 0 after the last pixel of a frame.
//   res channel (res_valid / res_stall / res_data) returns result words with
//   their coordinates. a border pixel comes back unchanged; an interior pixel
//   comes back white or black once the pixel below-right of it has arrived.
//   one input can release up to two words (interior first, then its own
//   border word); last_in_step marks the final word of an input.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   frame_width (index 0) and frame_height (index 1); always ready, to be
//   written only while the unit is idle.
// timing: an accepted pixel's words pass the line buffer read stage, then the
//   result register. one pixel per cycle is sustained while res_stall is low and
//   each input releases at most one word; an input that releases two words
//   holds the result register until both have left through the single output port.
// reset clears the counters, the window and all valid flags; the line buffers
//   need no clearing. a stalled result holds its word and, once the stages
//   behind it are full, pix_stall rises.
`default_nettype none

module sobel_edge_threshold_stream_unit
    import sobel_et_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pix_valid,
    output logic           pix_stall,
    input  wire pixel_in_t pix_data,
    output logic           res_valid,
    input  wire logic      res_stall,
    output result_t        res_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WCW   = (COL_W + 1 > 11) ? COL_W + 1 : 11;
    localparam int HCW   = (ROW_W + 1 > 13) ? ROW_W + 1 : 13;

    // configuration
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // line buffer read stage
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    pixel_in_t        s1_pix_reg;
    logic             s1_int_reg;
    logic             s1_bord_reg;
    logic             s1_byp_reg;
    logic [7:0]       byp_blue_reg;
    logic [7:0]       byp_mid_reg;

    // result register
    logic             s2_int_reg;
    logic             s2_bord_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    pixel_in_t        s2_pix_reg;
    logic             s2_white_reg;

    logic [7:0] win_reg  [9];
    logic [7:0] win_next [9];

    logic [WCW-1:0]   fw_x, w_eff_x;
    logic [HCW-1:0]   fh_x, h_eff_x;
    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic             last_col, last_row;
    logic             interior_now, border_now;
    logic             pix_ok, res_ok, s1_adv, s2_free;
    logic [7:0]       above_q, two_q, mid_eff, top_eff;
    logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
    logic [19:0]      gx_sq, gy_sq;
    logic [MAG_W-1:0] mag;
    logic             white;
    logic [ROW_W-1:0] out_r;
    logic [COL_W-1:0] out_c;
    logic [ROW_W+11:0] out_r_x;
    logic [COL_W+9:0]  out_c_x;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // effective frame size: zero reads as one, large values clamp
    always_comb
    begin
        fw_x = WCW'(frame_width_reg);
        fh_x = HCW'(frame_height_reg);
        if (fw_x == '0)
            w_eff_x = WCW'(1);
        else if (fw_x > WCW'(MAX_WIDTH))
            w_eff_x = WCW'(MAX_WIDTH);
        else
            w_eff_x = fw_x;
        if (fh_x == '0)
            h_eff_x = HCW'(1);
        else if (fh_x > HCW'(MAX_HEIGHT))
            h_eff_x = HCW'(MAX_HEIGHT);
        else
            h_eff_x = fh_x;
        w_eff = w_eff_x[COL_W:0];
        h_eff = h_eff_x[ROW_W:0];
    end

    // position of the incoming pixel, saturated into the frame
    always_comb
    begin
        if ({1'b0, col_reg} >= w_eff)
            c_cur = COL_W'(w_eff - (COL_W+1)'(1));
        else
            c_cur = col_reg;
        if ({1'b0, row_reg} >= h_eff)
            r_cur = ROW_W'(h_eff - (ROW_W+1)'(1));
        else
            r_cur = row_reg;
        last_col     = ({1'b0, c_cur} == w_eff - (COL_W+1)'(1));
        last_row     = ({1'b0, r_cur} == h_eff - (ROW_W+1)'(1));
        interior_now = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
        border_now   = (r_cur == '0) || (c_cur == '0) || last_row || last_col;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r_cur + ROW_W'(1);
        end
        else
        begin
            col_next = c_cur + COL_W'(1);
            row_next = r_cur;
        end
    end

    // handshake
    assign res_valid = s2_int_reg | s2_bord_reg;
    assign res_ok    = res_valid && !res_stall;
    assign s2_free   = !res_valid || (res_ok && !(s2_int_reg && s2_bord_reg));
    assign s1_adv    = s1_valid_reg && s2_free;
    assign pix_stall = s1_valid_reg && !s2_free;
    assign pix_ok    = pix_valid && !pix_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_ok)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (pix_ok)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ok)
        begin
            s1_col_reg  <= c_cur;
            s1_row_reg  <= r_cur;
            s1_pix_reg  <= pix_data;
            s1_int_reg  <= interior_now;
            s1_bord_reg <= border_now;
            // the word leaving now writes the address being read
            s1_byp_reg  <= s1_adv && (s1_col_reg == c_cur);
        end
        if (s1_adv)
        begin
            byp_blue_reg <= s1_pix_reg.in_blue;
            byp_mid_reg  <= mid_eff;
        end
    end

    sobel_et_ram #(
        .DATA_W (8),
        .DEPTH  (MAX_WIDTH)
    ) u_line_above (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg.in_blue),
        .rd_en   (pix_ok),
        .rd_addr (c_cur),
        .rd_data (above_q)
    );

    sobel_et_ram #(
        .DATA_W (8),
        .DEPTH  (MAX_WIDTH)
    ) u_line_two_above (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (mid_eff),
        .rd_en   (pix_ok),
        .rd_addr (c_cur),
        .rd_data (two_q)
    );

    assign mid_eff = s1_byp_reg ? byp_blue_reg : above_q;
    assign top_eff = s1_byp_reg ? byp_mid_reg  : two_q;

    // window shift and gradients
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]   = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = top_eff;
        win_next[5] = mid_eff;
        win_next[8] = s1_pix_reg.in_blue;

        gx_pos = {2'b00, win_next[2]} + {1'b0, win_next[5], 1'b0} + {2'b00, win_next[8]};
        gx_neg = {2'b00, win_next[0]} + {1'b0, win_next[3], 1'b0} + {2'b00, win_next[6]};
        gy_pos = {2'b00, win_next[6]} + {1'b0, win_next[7], 1'b0} + {2'b00, win_next[8]};
        gy_neg = {2'b00, win_next[0]} + {1'b0, win_next[1], 1'b0} + {2'b00, win_next[2]};
        gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        gx_sq  = gx_abs * gx_abs;
        gy_sq  = gy_abs * gy_abs;
        mag    = {1'b0, gx_sq} + {1'b0, gy_sq};
        white  = mag > EDGE_LIMIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_int_reg  <= 1'b0;
            s2_bord_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
                s2_int_reg  <= s1_int_reg;
                s2_bord_reg <= s1_bord_reg;
            end
            else if (res_ok)
            begin
                // interior word goes first, then the border word
                if (s2_int_reg)
                    s2_int_reg <= 1'b0;
                else
                    s2_bord_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_white_reg <= white;
        end
    end

    // output word
    always_comb
    begin
        if (s2_int_reg)
        begin
            out_r = s2_row_reg - ROW_W'(1);
            out_c = s2_col_reg - COL_W'(1);
        end
        else
        begin
            out_r = s2_row_reg;
            out_c = s2_col_reg;
        end
        out_r_x = {12'd0, out_r};
        out_c_x = {10'd0, out_c};
        res_data.out_row = out_r_x[11:0];
        res_data.out_col = out_c_x[9:0];
        if (s2_int_reg)
        begin
            res_data.out_red      = s2_white_reg ? PIX_WHITE : PIX_BLACK;
            res_data.out_green    = s2_white_reg ? PIX_WHITE : PIX_BLACK;
            res_data.out_blue     = s2_white_reg ? PIX_WHITE : PIX_BLACK;
            res_data.last_in_step = !s2_bord_reg;
        end
        else
        begin
            res_data.out_red      = s2_pix_reg.in_red;
            res_data.out_green    = s2_pix_reg.in_green;
            res_data.out_blue     = s2_pix_reg.in_blue;
            res_data.last_in_step = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/sobel_et_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; used for the line buffers
`default_nettype none

module sobel_et_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire
